### src/tpei_pkg.sv
// Package for the triangle/plane edge intersection block.
// Holds the register width and the configuration register indexes; no dependencies.
package tpei_pkg;

  localparam int REG_BITS = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_NORMAL_X = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z = 3'd2;
  localparam logic [2:0] REG_OFFSET   = 3'd3;
  localparam logic [2:0] REG_MIN_DEN  = 3'd4;

endpackage

### src/tpei_dot.sv
// One lane of the plane distance: dot product of a vertex with the normal.
// Products are floor-shifted by FRAC bits, then summed. No dependencies.
module tpei_dot #(
  parameter int FRAC = 16,
  parameter int DW   = 50
) (
  input  logic                 clk,
  input  logic signed [31:0]   px,
  input  logic signed [31:0]   py,
  input  logic signed [31:0]   pz,
  input  logic signed [31:0]   nx,
  input  logic signed [31:0]   ny,
  input  logic signed [31:0]   nz,
  output logic signed [DW-1:0] distance
);

  logic signed [63:0] prod_x;
  logic signed [63:0] prod_y;
  logic signed [63:0] prod_z;

  // Register each product; arithmetic shift gives the floor rounding.
  always_ff @(posedge clk) begin
    prod_x <= 64'(px) * 64'(nx);
    prod_y <= 64'(py) * 64'(ny);
    prod_z <= 64'(pz) * 64'(nz);
  end

  // Each shifted product needs 64 - FRAC bits; the sum of three needs two more.
  always_ff @(posedge clk) begin
    distance <= DW'(prod_x >>> FRAC) + DW'(prod_y >>> FRAC) + DW'(prod_z >>> FRAC);
  end

endmodule

### src/tpei_edge.sv
// One edge lane: hit test and pipelined restoring division for the parameter.
// No dependencies; pure arithmetic.
module tpei_edge #(
  parameter int DW    = 50,
  parameter int PBITS = 16
) (
  input  logic                 clk,
  input  logic signed [DW-1:0] s_start,
  input  logic signed [DW-1:0] s_end,
  input  logic signed [31:0]   offset,
  input  logic        [31:0]   min_den,
  output logic                 hit,
  output logic [PBITS:0]       param
);

  localparam int STG = PBITS + 1;
  localparam int NW  = DW + 2;
  localparam int RW  = NW + 1;

  logic signed [NW-1:0] num;
  logic signed [NW-1:0] den;
  logic        [NW-1:0] an;
  logic        [NW-1:0] ad;
  logic                 hit_c;

  always_comb begin
    num = NW'(offset) - NW'(s_start);
    den = NW'(s_end) - NW'(s_start);
    an = num[NW-1] ? NW'(-num) : NW'(num);
    ad = den[NW-1] ? NW'(-den) : NW'(den);
    if (ad <= NW'(min_den)) begin
      hit_c = 1'b0;
    end else if (num == '0) begin
      hit_c = 1'b1;
    end else begin
      hit_c = (num[NW-1] == den[NW-1]) && (an <= ad);
    end
  end

  // Division pipeline: one quotient bit per stage.
  logic [RW-1:0]  rem [STG+1];
  logic [NW-1:0]  dv  [STG+1];
  logic [PBITS:0] qt  [STG+1];
  logic [STG:0]   hv;

  always_ff @(posedge clk) begin
    rem[0] <= RW'(an);
    dv[0]  <= ad;
    qt[0]  <= '0;
    hv[0]  <= hit_c;
  end

  for (genvar k = 0; k < STG; k++) begin : g_div
    logic [RW-1:0] r_in;
    logic          ge;
    always_comb begin
      r_in = (k == 0) ? rem[k] : {rem[k][NW-1:0], 1'b0};
      ge = r_in >= RW'(dv[k]);
    end
    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? r_in - RW'(dv[k]) : r_in;
      dv[k+1]  <= dv[k];
      qt[k+1]  <= {qt[k][PBITS-1:0], ge};
      hv[k+1]  <= hv[k];
    end
  end

  assign hit = hv[STG];
  assign param = qt[STG];

endmodule

### src/tpei_merge.sv
// Merge stage: picks the first two hit edges in edge order and counts hits.
// Used by the top level after the edge lanes.
module tpei_merge #(
  parameter int IBITS = 24,
  parameter int PBITS = 16
) (
  input  logic             clk,
  input  logic [2:0]       hits,
  input  logic [IBITS-1:0] idx0,
  input  logic [IBITS-1:0] idx1,
  input  logic [IBITS-1:0] idx2,
  input  logic [PBITS:0]   p0,
  input  logic [PBITS:0]   p1,
  input  logic [PBITS:0]   p2,
  output logic [IBITS-1:0] a_start,
  output logic [IBITS-1:0] a_end,
  output logic [PBITS:0]   a_param,
  output logic [IBITS-1:0] b_start,
  output logic [IBITS-1:0] b_end,
  output logic [PBITS:0]   b_param,
  output logic [1:0]       count
);

  logic [IBITS-1:0] a_start_next, a_end_next, b_start_next, b_end_next;
  logic [PBITS:0]   a_param_next, b_param_next;

  // Edge 0 is 0-1, edge 1 is 1-2, edge 2 is 2-0.
  always_comb begin
    a_start_next = '0; a_end_next = '0; a_param_next = '0;
    b_start_next = '0; b_end_next = '0; b_param_next = '0;
    if (hits[0]) begin
      a_start_next = idx0; a_end_next = idx1; a_param_next = p0;
      if (hits[1]) begin
        b_start_next = idx1; b_end_next = idx2; b_param_next = p1;
      end else if (hits[2]) begin
        b_start_next = idx2; b_end_next = idx0; b_param_next = p2;
      end
    end else if (hits[1]) begin
      a_start_next = idx1; a_end_next = idx2; a_param_next = p1;
      if (hits[2]) begin
        b_start_next = idx2; b_end_next = idx0; b_param_next = p2;
      end
    end else if (hits[2]) begin
      a_start_next = idx2; a_end_next = idx0; a_param_next = p2;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    a_start <= a_start_next; a_end <= a_end_next; a_param <= a_param_next;
    b_start <= b_start_next; b_end <= b_end_next; b_param <= b_param_next;
    count <= 2'({1'b0, hits[0]} + {1'b0, hits[1]} + {1'b0, hits[2]});
  end

endmodule

### src/triangle_plane_edge_intersect.sv
// Top level of the triangle/plane edge intersection block.
// Uses tpei_pkg, tpei_dot, tpei_edge and tpei_merge.
//
// A triangle is taken on every cycle in which start is high and busy is
// low; busy is always low, so one triangle enters per clock. Each result
// beat appears on done after passing the multiplier and sum stages of
// the three distance lanes, the one-bit-per-stage divider in each edge
// lane and the merge register. The receiver cannot stall. The user must
// write configuration only while idle; the block does not enforce it.
module triangle_plane_edge_intersect #(
  parameter int INDEX_BITS      = 24,
  parameter int COORD_FRAC_BITS = 16,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic [INDEX_BITS-1:0]        first_index,
  input  logic [INDEX_BITS-1:0]        second_index,
  input  logic [INDEX_BITS-1:0]        third_index,
  input  logic signed [31:0]           first_px,
  input  logic signed [31:0]           first_py,
  input  logic signed [31:0]           first_pz,
  input  logic signed [31:0]           second_px,
  input  logic signed [31:0]           second_py,
  input  logic signed [31:0]           second_pz,
  input  logic signed [31:0]           third_px,
  input  logic signed [31:0]           third_py,
  input  logic signed [31:0]           third_pz,
  output logic                         done,
  output logic [INDEX_BITS-1:0]        hit_a_start,
  output logic [INDEX_BITS-1:0]        hit_a_end,
  output logic [PARAM_FRAC_BITS:0]     hit_a_param,
  output logic [INDEX_BITS-1:0]        hit_b_start,
  output logic [INDEX_BITS-1:0]        hit_b_end,
  output logic [PARAM_FRAC_BITS:0]     hit_b_param,
  output logic [1:0]                   hit_count
);

  localparam int LAT = PARAM_FRAC_BITS + 5;
  // A floored product needs 64 - COORD_FRAC_BITS bits; a sum of three, two more.
  localparam int DIST_W = 66 - COORD_FRAC_BITS;

  logic signed [31:0] normal_x, normal_y, normal_z, plane_offset;
  logic [31:0] min_denominator;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= 32'sd1 <<< COORD_FRAC_BITS;
      plane_offset <= '0;
      min_denominator <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpei_pkg::REG_NORMAL_X: normal_x <= cfg_data;
        tpei_pkg::REG_NORMAL_Y: normal_y <= cfg_data;
        tpei_pkg::REG_NORMAL_Z: normal_z <= cfg_data;
        tpei_pkg::REG_OFFSET:   plane_offset <= cfg_data;
        tpei_pkg::REG_MIN_DEN:  min_denominator <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Distance lanes, one per vertex.
  logic signed [DIST_W-1:0] s0, s1, s2;
  tpei_dot #(.FRAC(COORD_FRAC_BITS), .DW(DIST_W)) u_dot0 (.clk, .px(first_px),
    .py(first_py), .pz(first_pz), .nx(normal_x), .ny(normal_y), .nz(normal_z),
    .distance(s0));
  tpei_dot #(.FRAC(COORD_FRAC_BITS), .DW(DIST_W)) u_dot1 (.clk, .px(second_px),
    .py(second_py), .pz(second_pz), .nx(normal_x), .ny(normal_y), .nz(normal_z),
    .distance(s1));
  tpei_dot #(.FRAC(COORD_FRAC_BITS), .DW(DIST_W)) u_dot2 (.clk, .px(third_px),
    .py(third_py), .pz(third_pz), .nx(normal_x), .ny(normal_y), .nz(normal_z),
    .distance(s2));

  // Edge lanes.
  logic [2:0] hits;
  logic [PARAM_FRAC_BITS:0] p0, p1, p2;
  tpei_edge #(.DW(DIST_W), .PBITS(PARAM_FRAC_BITS)) u_e0 (.clk, .s_start(s0),
    .s_end(s1), .offset(plane_offset), .min_den(min_denominator), .hit(hits[0]),
    .param(p0));
  tpei_edge #(.DW(DIST_W), .PBITS(PARAM_FRAC_BITS)) u_e1 (.clk, .s_start(s1),
    .s_end(s2), .offset(plane_offset), .min_den(min_denominator), .hit(hits[1]),
    .param(p1));
  tpei_edge #(.DW(DIST_W), .PBITS(PARAM_FRAC_BITS)) u_e2 (.clk, .s_start(s2),
    .s_end(s0), .offset(plane_offset), .min_den(min_denominator), .hit(hits[2]),
    .param(p2));

  // Index delay line, aligned with the edge lanes' output.
  logic [INDEX_BITS-1:0] i0 [LAT-1];
  logic [INDEX_BITS-1:0] i1 [LAT-1];
  logic [INDEX_BITS-1:0] i2 [LAT-1];
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    i0[0] <= first_index;
    i1[0] <= second_index;
    i2[0] <= third_index;
    for (int k = 1; k < LAT - 1; k++) begin
      i0[k] <= i0[k-1];
      i1[k] <= i1[k-1];
      i2[k] <= i2[k-1];
    end
  end

  // Valid shift line for the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  tpei_merge #(.IBITS(INDEX_BITS), .PBITS(PARAM_FRAC_BITS)) u_merge (
    .clk, .hits, .idx0(i0[LAT-2]), .idx1(i1[LAT-2]), .idx2(i2[LAT-2]),
    .p0, .p1, .p2,
    .a_start(hit_a_start), .a_end(hit_a_end), .a_param(hit_a_param),
    .b_start(hit_b_start), .b_end(hit_b_end), .b_param(hit_b_param),
    .count(hit_count));

  assign done = vld[LAT-1];

  // A result beat always follows its start beat by the pipeline latency.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done) else $error("result beat missing");
  // No hit parameters are set when no edge was hit.
  a_order: assert property (@(posedge clk) disable iff (rst)
    done && hit_count == 2'd0 |-> hit_a_param == '0 && hit_b_param == '0)
    else $error("hit fields set with zero count");
  // The first hit parameter never exceeds 1.0.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> hit_a_param <= (1 << PARAM_FRAC_BITS))
    else $error("parameter out of range");

endmodule
